// ===== hw/rtl/positional_insert_delete_array_top_assert.svh =====
// Assertion macros for the positional insert/delete array
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH

// same-cycle implication
`define PIDA_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication
`define PIDA_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/pida_pkg.sv =====
`default_nettype none
package pida_pkg;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_DELETE = 2'd2;
	localparam logic [1:0] FUNC_LIST   = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;
	localparam logic [1:0] STATUS_EMPTY   = 2'd3;

	typedef enum logic [2:0] {
		CMD_HOLD = 3'd0,
		CMD_INS  = 3'd1,
		CMD_APP  = 3'd2,
		CMD_DEL  = 3'd3,
		CMD_ROT  = 3'd4
	} cell_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pida_cell.sv =====
`default_nettype none
module pida_cell #(
	parameter int WORD_BITS = 32,
	parameter int IDX_W     = 6,
	parameter int IDX       = 0
) (
	input  wire                        clk,
	input  wire pida_pkg::cell_cmd_t   cmd,
	input  wire logic [IDX_W-1:0]      at,
	input  wire logic [WORD_BITS-1:0]  elem,
	input  wire logic [WORD_BITS-1:0]  left,
	input  wire logic [WORD_BITS-1:0]  right,
	input  wire logic [WORD_BITS-1:0]  wrap,
	output logic      [WORD_BITS-1:0]  data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [WORD_BITS-1:0] data_q;
	logic [WORD_BITS-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (cmd)
			pida_pkg::CMD_INS: begin
				if (MY_IDX == at) data_d = elem;
				else if (MY_IDX > at) data_d = left;
			end
			pida_pkg::CMD_APP: begin
				if (MY_IDX == at) data_d = elem;
			end
			pida_pkg::CMD_DEL: begin
				if (MY_IDX >= at) data_d = right;
			end
			pida_pkg::CMD_ROT: begin
				if (MY_IDX < at) data_d = right;
				else if (MY_IDX == at) data_d = wrap;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/positional_insert_delete_array_top.sv =====
// Insert, append and delete: one result, registered in the cycle after the word is taken;
// only the cell at the position and those after it change, one word per cycle unless stalled.
// List: one result per stored element, the chain rotating one cell per cycle unless stalled,
// so no new word is taken until the last is sent; an empty store gives one EMPTY result.
// Reset (arst_n low, asynchronous) empties the store; cell contents are not cleared.
`default_nettype none
`include "positional_insert_delete_array_top_assert.svh"
module positional_insert_delete_array_top #(
	parameter int CAPACITY  = 32,
	parameter int WORD_BITS = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire logic [1:0]   func,
	input  wire logic [5:0]   position,
	input  wire logic [31:0]  element,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [1:0]        status,
	output logic [31:0]       value,
	output logic [4:0]        slot,
	output logic [5:0]        count,
	output logic              last
);

	localparam int IDX_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (IDX_W > 6) ? IDX_W : 6;
	localparam logic [IDX_W-1:0] FULL = IDX_W'(CAPACITY);

	logic [IDX_W-1:0]     fill_q;
	logic [IDX_W-1:0]     list_idx_q;
	logic                 busy_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [31:0]          value_q;
	logic [4:0]           slot_q;
	logic [5:0]           count_q;
	logic                 last_q;

	logic                 out_free;
	logic                 accept;
	logic                 emit;
	logic                 list_done;
	logic                 pos_ok;
	logic                 full;
	logic [CMP_W-1:0]     pos_x;
	logic [CMP_W-1:0]     fill_x;
	logic [IDX_W-1:0]     fill_last;
	logic [WORD_BITS-1:0] elem_w;

	pida_pkg::cell_cmd_t  cmd;
	logic [IDX_W-1:0]     at;
	logic [1:0]           res_status;
	logic [IDX_W-1:0]     fill_d;

	logic [WORD_BITS-1:0] cell_data [CAPACITY];

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = busy_q || !out_free;
	assign accept    = in_valid && !in_stall;
	assign emit      = busy_q && out_free;
	assign fill_last = fill_q - IDX_W'(1);
	assign list_done = list_idx_q == fill_last;

	assign pos_x  = CMP_W'(position);
	assign fill_x = CMP_W'(fill_q);
	assign pos_ok = (pos_x != '0) && (pos_x <= fill_x);
	assign full   = fill_q == FULL;
	assign elem_w = WORD_BITS'($unsigned(element));

	always_comb begin
		cmd        = pida_pkg::CMD_HOLD;
		at         = IDX_W'(pos_x - CMP_W'(1));
		res_status = pida_pkg::STATUS_OK;
		fill_d     = fill_q;
		if (emit) begin
			cmd = pida_pkg::CMD_ROT;
			at  = fill_last;
		end else if (accept) begin
			unique case (func)
				pida_pkg::FUNC_INSERT: begin
					if (!pos_ok) res_status = pida_pkg::STATUS_INVALID;
					else if (full) res_status = pida_pkg::STATUS_FULL;
					else begin
						cmd    = pida_pkg::CMD_INS;
						fill_d = fill_q + IDX_W'(1);
					end
				end
				pida_pkg::FUNC_APPEND: begin
					at = fill_q;
					if (full) res_status = pida_pkg::STATUS_FULL;
					else begin
						cmd    = pida_pkg::CMD_APP;
						fill_d = fill_q + IDX_W'(1);
					end
				end
				pida_pkg::FUNC_DELETE: begin
					if (!pos_ok) res_status = pida_pkg::STATUS_INVALID;
					else begin
						cmd    = pida_pkg::CMD_DEL;
						fill_d = fill_q - IDX_W'(1);
					end
				end
				default: begin
					if (fill_q == '0) res_status = pida_pkg::STATUS_EMPTY;
				end
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		pida_cell #(
			.WORD_BITS (WORD_BITS),
			.IDX_W     (IDX_W),
			.IDX       (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.at    (at),
			.elem  (elem_w),
			.left  ((i == 0) ? cell_data[0] : cell_data[(i == 0) ? 0 : i - 1]),
			.right (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
			.wrap  (cell_data[0]),
			.data  (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			busy_q      <= 1'b0;
			list_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				list_idx_q  <= list_idx_q + IDX_W'(1);
				if (list_done) busy_q <= 1'b0;
			end else if (accept) begin
				list_idx_q <= '0;
				if (func == pida_pkg::FUNC_LIST && fill_q != '0) begin
					busy_q      <= 1'b1;
					out_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= pida_pkg::STATUS_OK;
			value_q  <= 32'($signed(cell_data[0]));
			slot_q   <= 5'(list_idx_q);
			count_q  <= 6'(fill_q);
			last_q   <= list_done;
		end else if (accept) begin
			status_q <= res_status;
			value_q  <= '0;
			slot_q   <= '0;
			count_q  <= 6'(fill_d);
			last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;
	assign slot      = slot_q;
	assign count     = count_q;
	assign last      = last_q;

	`PIDA_ASSERT_NOW(a_busy_nonempty, clk, arst_n, busy_q, fill_q != '0)
	`PIDA_ASSERT_NOW(a_idx_in_range, clk, arst_n, busy_q, list_idx_q < fill_q)
	`PIDA_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FULL)
	`PIDA_ASSERT_NEXT(a_accept_result, clk, arst_n, accept, out_valid_q || busy_q)

endmodule
`default_nettype wire

// ===== tb/positional_insert_delete_array_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module positional_insert_delete_array_checker #(
	parameter int CAPACITY  = 32,
	parameter int WORD_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [1:0]  func,
	input  wire  [5:0]  position,
	input  wire  [31:0] element,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [1:0]  status,
	input  wire  [31:0] value,
	input  wire  [4:0]  slot,
	input  wire  [5:0]  count,
	input  wire         last,
	output int          failures,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
		logic [4:0]  slot;
		logic [5:0]  count;
		logic        last;
	} array_result_t;

	array_result_t        due_results [$];
	logic [WORD_BITS-1:0] cells [CAPACITY];
	int                   fill;
	int                   mismatch_count = 0;
	int                   results_due    = 0;

	assign failures    = mismatch_count;
	assign outstanding = results_due;

	task automatic queue_result(input logic [1:0] st, input logic [31:0] v, input int s,
			input logic l);
		array_result_t r;
		r.status = st;
		r.value  = v;
		r.slot   = 5'(s);
		r.count  = 6'(fill);
		r.last   = l;
		due_results.push_back(r);
	endtask

	task automatic apply_operation(input logic [1:0] f, input logic [5:0] p,
			input logic [31:0] e);
		int                     at;
		logic [63:0]            wide_in;
		logic signed [WORD_BITS-1:0] w;
		logic signed [63:0]     wide_out;
		at      = int'(p);
		wide_in = {32'b0, e};
		case (f)
			pida_pkg::FUNC_INSERT: begin
				if (at == 0 || at > fill)
					queue_result(pida_pkg::STATUS_INVALID, 32'd0, 0, 1'b1);
				else if (fill >= CAPACITY)
					queue_result(pida_pkg::STATUS_FULL, 32'd0, 0, 1'b1);
				else begin
					for (int i = fill; i >= at; i--)
						cells[i] = cells[i-1];
					cells[at-1] = wide_in[WORD_BITS-1:0];
					fill++;
					queue_result(pida_pkg::STATUS_OK, 32'd0, 0, 1'b1);
				end
			end
			pida_pkg::FUNC_APPEND: begin
				if (fill >= CAPACITY)
					queue_result(pida_pkg::STATUS_FULL, 32'd0, 0, 1'b1);
				else begin
					cells[fill] = wide_in[WORD_BITS-1:0];
					fill++;
					queue_result(pida_pkg::STATUS_OK, 32'd0, 0, 1'b1);
				end
			end
			pida_pkg::FUNC_DELETE: begin
				if (at == 0 || at > fill)
					queue_result(pida_pkg::STATUS_INVALID, 32'd0, 0, 1'b1);
				else begin
					for (int i = at; i < fill; i++)
						cells[i-1] = cells[i];
					fill--;
					queue_result(pida_pkg::STATUS_OK, 32'd0, 0, 1'b1);
				end
			end
			default: begin
				if (fill == 0)
					queue_result(pida_pkg::STATUS_EMPTY, 32'd0, 0, 1'b1);
				else begin
					for (int i = 0; i < fill; i++) begin
						w        = cells[i];
						wide_out = w;
						queue_result(pida_pkg::STATUS_OK, wide_out[31:0], i, i + 1 == fill);
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		array_result_t got;
		array_result_t exp;
		if (!arst_n) begin
			fill = 0;
			due_results.delete();
			results_due <= 0;
		end else begin
			if (in_valid && !in_stall)
				apply_operation(func, position, element);
			if (out_valid && !out_stall) begin
				got = {status, value, slot, count, last};
				if (due_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected word: status %0d value %h slot %0d count %0d last %b",
							$time, got.status, got.value, got.slot, got.count, got.last);
				end else begin
					exp = due_results.pop_front();
					if (got !== exp) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: mismatch: expected status %0d value %h slot %0d count %0d last %b",
								$time, exp.status, exp.value, exp.slot, exp.count, exp.last);
							$display("%0t:   got status %0d value %h slot %0d count %0d last %b",
								$time, got.status, got.value, got.slot, got.count, got.last);
						end
					end
				end
			end
			results_due <= due_results.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/positional_insert_delete_array_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module positional_insert_delete_array_top_tb;

	localparam int CAPACITY    = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        out_stall = 1'b0;
	logic [1:0]  func      = pida_pkg::FUNC_LIST;
	logic [5:0]  position  = 6'd0;
	logic [31:0] element   = 32'd0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  status;
	logic [31:0] value;
	logic [4:0]  slot;
	logic [5:0]  count;
	logic        last;
	int          failures;
	int          outstanding;

	int   idle_pct   = 0;
	int   stall_pct  = 0;
	logic want_hold  = 1'b0;
	logic hold_done  = 1'b0;
	int   fill_est   = 0;
	int   peak_fill  = 0;
	int   words_sent = 0;
	int   lists_sent = 0;
	int   quiet_run  = 0;

	positional_insert_delete_array_top #(.CAPACITY(CAPACITY)) i_dut (.*);

	positional_insert_delete_array_checker #(.CAPACITY(CAPACITY)) i_checker (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// long hold first when asked, random stalls otherwise
	initial begin
		forever begin
			@(posedge clk);
			if (want_hold && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done <= 1'b1;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_run <= 0;
			else if (quiet_run >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else
				quiet_run <= quiet_run + 1;
		end
	end

	task automatic send_word(input logic [1:0] f, input logic [5:0] p, input logic [31:0] e);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		position <= p;
		element  <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		case (f)
			pida_pkg::FUNC_INSERT:
				if (p != 0 && p <= fill_est && fill_est < CAPACITY) fill_est++;
			pida_pkg::FUNC_APPEND: if (fill_est < CAPACITY) fill_est++;
			pida_pkg::FUNC_DELETE: if (p != 0 && p <= fill_est) fill_est--;
			default:               lists_sent++;
		endcase
		if (fill_est > peak_fill)
			peak_fill = fill_est;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int         target;
		int         k;
		logic [1:0] f;
		logic [5:0] p;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(pida_pkg::FUNC_LIST,   6'd0,  32'd0);
		send_word(pida_pkg::FUNC_INSERT, 6'd1,  32'h1234_5678);
		send_word(pida_pkg::FUNC_DELETE, 6'd1,  32'd0);
		send_word(pida_pkg::FUNC_APPEND, 6'd0,  32'h7FFF_FFFF);
		send_word(pida_pkg::FUNC_APPEND, 6'd63, 32'h8000_0000);
		send_word(pida_pkg::FUNC_APPEND, 6'd0,  32'h0000_0000);
		send_word(pida_pkg::FUNC_APPEND, 6'd0,  32'hFFFF_FFFF);
		send_word(pida_pkg::FUNC_INSERT, 6'd0,  32'hDEAD_BEEF);
		send_word(pida_pkg::FUNC_INSERT, 6'd1,  32'h5555_5555);
		send_word(pida_pkg::FUNC_INSERT, 6'd5,  32'hAAAA_AAAA);
		send_word(pida_pkg::FUNC_INSERT, 6'd7,  32'h0F0F_0F0F);
		send_word(pida_pkg::FUNC_INSERT, 6'd63, 32'hF0F0_F0F0);
		send_word(pida_pkg::FUNC_DELETE, 6'd0,  32'd0);
		send_word(pida_pkg::FUNC_DELETE, 6'd63, 32'd0);
		send_word(pida_pkg::FUNC_LIST,   6'd0,  32'd0);
		send_word(pida_pkg::FUNC_DELETE, 6'd6,  32'd0);
		send_word(pida_pkg::FUNC_DELETE, 6'd1,  32'd0);
		send_word(pida_pkg::FUNC_LIST,   6'd63, 32'hFFFF_FFFF);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 70; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 17; stall_pct = 17; end
			endcase
			for (int i = 0; i < 105; i++) begin
				if (i == 0)
					target = (ph % 2 == 0) ? CAPACITY : 0;
				else if (i % 35 == 0) begin
					k = $urandom_range(3);
					target = (k == 0) ? 0 : (k == 1) ? CAPACITY : $urandom_range(CAPACITY);
				end
				if (ph == 0 && i == 60)
					want_hold <= 1'b1;
				if (ph == 1 && i == 50)
					settle();
				k = $urandom_range(99);
				if (k < 8) begin
					f = 2'($urandom);
					p = 6'($urandom);
				end else if (k < 18) begin
					f = pida_pkg::FUNC_LIST;
					p = 6'($urandom);
				end else if (fill_est < target || (fill_est == target && k < 45)) begin
					if (fill_est > 0 && k % 2 == 1) begin
						f = pida_pkg::FUNC_INSERT;
						p = 6'($urandom_range(fill_est, 1));
					end else begin
						f = pida_pkg::FUNC_APPEND;
						p = 6'($urandom);
					end
				end else if (fill_est > 0) begin
					f = pida_pkg::FUNC_DELETE;
					p = 6'($urandom_range(fill_est, 1));
				end else begin
					f = pida_pkg::FUNC_APPEND;
					p = 6'($urandom);
				end
				send_word(f, p, $urandom);
			end
			settle();
		end

		repeat (40) @(posedge clk);
		$display("%0d words sent, %0d of them lists; fill peaked at %0d of %0d",
			words_sent, lists_sent, peak_fill, CAPACITY);
		$display("idle mixes: none, sender 70%%, receiver 70%%, both 17%%, plus a %0d-cycle hold",
			HOLD_CYCLES);
		if (failures == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pida_pkg.sv
hw/rtl/pida_cell.sv
hw/rtl/positional_insert_delete_array_top.sv
tb/positional_insert_delete_array_checker.sv
tb/positional_insert_delete_array_top_tb.sv
